[hdl/stsr_pkg.sv]
// Shared types and constants for the sorted table search block.
// No dependencies; imported by stsr_search_ctrl and the top module.
`timescale 1ns / 1ps

package stsr_pkg;

  localparam int unsigned TableDepthDef = 1024;
  localparam int unsigned ValueWidthDef = 32;

  localparam int unsigned IdxW    = 10;  // entry_index field
  localparam int unsigned SizeW   = 11;  // table_size register
  localparam int unsigned RankW   = 11;  // rank field
  localparam int unsigned StatusW = 2;

  localparam int unsigned OutDataW = ((RankW + 7) / 8) * 8;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SEARCH = 1'b1
  } op_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_HIT   = 2'd0,
    STATUS_MISS  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_OUT
  } state_e;

  typedef struct packed {
    status_e           status;
    logic [RankW-1:0]  rank;
  } res_t;

endpackage

[hdl/stsr_table_ram.sv]
// Table store: one write port, one read port with registered read data.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module stsr_table_ram #(
  parameter int unsigned Depth  = 1024,
  parameter int unsigned Width  = 32,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/stsr_search_ctrl.sv]
// Bisection sequencer: one probe per cycle through the shared compare unit.
// Uses stsr_pkg; drives the read address of stsr_table_ram.
`timescale 1ns / 1ps

module stsr_search_ctrl import stsr_pkg::*; #(
  parameter int unsigned Depth  = TableDepthDef,
  parameter int unsigned Width  = ValueWidthDef,
  localparam int unsigned AddrW = $clog2(Depth),
  localparam int unsigned CntW  = AddrW + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,   // search item accepted
  input  logic [Width-1:0] key_i,
  input  logic [SizeW-1:0] size_i,
  input  logic [Width-1:0] rdata_i,
  input  logic             take_i,    // output register can load
  output logic [AddrW-1:0] raddr_o,
  output logic             ready_o,
  output logic             done_o,
  output res_t             res_o
);

  state_e state_q, state_d;

  logic [AddrW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [Width-1:0] key_q;
  res_t             res_q, res_d;

  logic [CntW-1:0]  n;
  logic             hit, key_above, at_hi, at_lo;
  logic [AddrW:0]   sum_up, sum_dn;
  logic [AddrW-1:0] mid_up, mid_dn, lo_inc, hi_dec, first_hi;
  logic [AddrW:0]   first_sum;

  // Saturate the loaded size to the table depth
  always_comb begin
    if (32'(size_i) > 32'(Depth)) begin
      n = CntW'(Depth);
    end else begin
      n = CntW'(size_i);
    end
  end

  // Shared compare unit
  assign hit       = (rdata_i == key_q);
  assign key_above = ($signed(key_q) > $signed(rdata_i));
  assign at_hi     = (mid_q == hi_q);
  assign at_lo     = (mid_q == lo_q);

  assign lo_inc    = mid_q + AddrW'(1);
  assign hi_dec    = mid_q - AddrW'(1);
  assign sum_up    = {1'b0, lo_inc} + {1'b0, hi_q};
  assign sum_dn    = {1'b0, lo_q} + {1'b0, hi_dec};
  assign mid_up    = sum_up[AddrW:1];
  assign mid_dn    = sum_dn[AddrW:1];

  assign first_hi  = AddrW'(n - CntW'(1));
  assign first_sum = {1'b0, first_hi};
  assign raddr_o   = mid_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = (n == '0) ? ST_OUT : ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (hit || (key_above && at_hi) || (!key_above && at_lo)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    lo_d  = lo_q;
    hi_d  = hi_q;
    mid_d = mid_q;
    res_d = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          lo_d  = '0;
          hi_d  = first_hi;
          mid_d = first_sum[AddrW:1];
          res_d = '{status: STATUS_EMPTY, rank: '0};
        end
      end
      ST_PROBE: begin
        if (hit) begin
          res_d = '{status: STATUS_HIT, rank: RankW'(mid_q)};
        end else if (key_above) begin
          if (at_hi) begin
            res_d = '{status: STATUS_MISS, rank: RankW'(CntW'(mid_q) + CntW'(1))};
          end else begin
            lo_d  = lo_inc;
            mid_d = mid_up;
          end
        end else begin
          if (at_lo) begin
            // below the lowest probe: step back one, floored at slot zero
            res_d = '{status: STATUS_MISS,
                      rank: (mid_q == '0) ? '0 : RankW'(hi_dec)};
          end else begin
            hi_d  = hi_dec;
            mid_d = mid_dn;
          end
        end
      end
      default: ;
    endcase
  end

  assign ready_o = (state_q == ST_IDLE);
  assign done_o  = (state_q == ST_OUT);
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    res_q <= res_d;
    if (start_i && (state_q == ST_IDLE)) begin
      key_q <= key_i;
    end
  end

endmodule

[hdl/sorted_table_search_with_rank_top.sv]
// Search item: accepting it issues the first read, then the sequencer probes
// once per table read (ceil(log2(table_size+1)) probes at most, 11 for 1024
// entries), then hands the result over to the output register.
// Write items go straight to the table; an empty table answers without probes.
// The probe loop through the table read port sets the rate. rst_ni clears
// the sequencer, output valid and table_size; table contents are undefined.
`timescale 1ns / 1ps

module sorted_table_search_with_rank_top import stsr_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDef,
  parameter int unsigned VALUE_WIDTH = ValueWidthDef,
  localparam int unsigned InDataW    = ((IdxW + VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  // table_size register
  input  logic                cfg_we_i,
  input  logic [SizeW-1:0]    cfg_wdata_i,

  // input items
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // entry_index, value (low bit up)
  input  logic [0:0]          s_axis_tuser,   // operation

  // result items
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // rank
  output logic [StatusW-1:0]  m_axis_tuser    // status
);

  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);

  logic [SizeW-1:0]       size_q;
  logic                   accept, ctrl_ready, ctrl_done, take;
  logic                   is_search, wr_en;
  logic [IdxW-1:0]        entry_index;
  logic [VALUE_WIDTH-1:0] value;
  logic [AddrW-1:0]       raddr;
  logic [VALUE_WIDTH-1:0] rdata;
  res_t                   ctrl_res;
  logic                   out_valid_q;
  res_t                   out_res_q;

  assign entry_index = s_axis_tdata[IdxW-1:0];
  assign value       = s_axis_tdata[IdxW +: VALUE_WIDTH];

  assign s_axis_tready = ctrl_ready;
  assign accept        = s_axis_tvalid && ctrl_ready;
  assign is_search     = (op_e'(s_axis_tuser[0]) == OP_SEARCH);

  // writes beyond the table are dropped
  assign wr_en = accept && !is_search && (32'(entry_index) < 32'(TABLE_DEPTH));

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= '0;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  stsr_table_ram #(
    .Depth (TABLE_DEPTH),
    .Width (VALUE_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (AddrW'(entry_index)),
    .wdata_i (value),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  stsr_search_ctrl #(
    .Depth (TABLE_DEPTH),
    .Width (VALUE_WIDTH)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && is_search),
    .key_i   (value),
    .size_i  (size_q),
    .rdata_i (rdata),
    .take_i  (take),
    .raddr_o (raddr),
    .ready_o (ctrl_ready),
    .done_o  (ctrl_done),
    .res_o   (ctrl_res)
  );

  // Output register: loads when empty or being drained this cycle
  assign take = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_done && take) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_done && take) begin
      out_res_q <= ctrl_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(out_res_q.rank);
  assign m_axis_tuser  = out_res_q.status;

endmodule
